@@ rtl/nhm64_pkg.sv @@
package nhm64_pkg;

	// Mixing constant shared by the word scramble, the tail and the finalization.
	localparam logic [31:0] MIX_M = 32'h5BD1_E995;

	// Value of the seed register after reset.
	localparam logic [31:0] SEED_RST = 32'hEE6B_27EB;

	// Shift amounts of the word scramble and of the four finalization rounds.
	localparam int unsigned MIX_R = 24;
	localparam int unsigned FIN_R1 = 18;
	localparam int unsigned FIN_R2 = 22;
	localparam int unsigned FIN_R3 = 17;
	localparam int unsigned FIN_R4 = 19;

	// Longest name that is accepted without a length error.
	localparam int unsigned MAX_NAME_BYTES = 255;

	// Datapath operations: none, or one for each pass through the shared multiplier.
	localparam logic [3:0] OP_NONE = 4'd0;
	localparam logic [3:0] OP_K1 = 4'd1;
	localparam logic [3:0] OP_K2 = 4'd2;
	localparam logic [3:0] OP_HALF = 4'd3;
	localparam logic [3:0] OP_TAIL = 4'd4;
	localparam logic [3:0] OP_F1 = 4'd5;
	localparam logic [3:0] OP_F2 = 4'd6;
	localparam logic [3:0] OP_F3 = 4'd7;
	localparam logic [3:0] OP_F4 = 4'd8;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       accept;
		logic [3:0] op;
		logic       load_out;
	} nhm64_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic word_done;
		logic last_in;
		logic last_held;
		logic out_free;
	} nhm64_stat_t;

	// Low 32 bits of a 32 by 32 product.
	function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
		logic [63:0] p;
		p = a * b;
		return p[31:0];
	endfunction

endpackage

@@ rtl/nhm64_item_if.sv @@
interface nhm64_item_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic [7:0] name_length;
	logic       last_byte;

	modport source (output valid, output data_byte, output name_length, output last_byte,
		input ready);
	modport sink (input valid, input data_byte, input name_length, input last_byte,
		output ready);
endinterface

@@ rtl/nhm64_result_if.sv @@
interface nhm64_result_if;
	logic        valid;
	logic        ready;
	logic [62:0] hash_value;
	logic        length_error;

	modport source (output valid, output hash_value, output length_error, input ready);
	modport sink (input valid, input hash_value, input length_error, output ready);
endinterface

@@ rtl/nhm64_cfg_if.sv @@
interface nhm64_cfg_if;
	logic        valid;
	logic        ready;
	logic [31:0] hash_seed;

	modport source (output valid, output hash_seed, input ready);
	modport sink (input valid, input hash_seed, output ready);
endinterface

@@ rtl/nhm64_ctrl.sv @@
module nhm64_ctrl (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   item_valid,
	output logic                   item_ready,
	input  nhm64_pkg::nhm64_stat_t stat,
	output nhm64_pkg::nhm64_cmd_t  cmd
);

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_K1 = 4'd1;
	localparam logic [3:0] ST_K2 = 4'd2;
	localparam logic [3:0] ST_HALF = 4'd3;
	localparam logic [3:0] ST_TAIL = 4'd4;
	localparam logic [3:0] ST_F1 = 4'd5;
	localparam logic [3:0] ST_F2 = 4'd6;
	localparam logic [3:0] ST_F3 = 4'd7;
	localparam logic [3:0] ST_F4 = 4'd8;
	localparam logic [3:0] ST_OUT = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign item_ready = (state_q == ST_IDLE);

	// Next state and the command for the datapath.
	always_comb begin
		state_d = state_q;
		cmd.accept = 1'b0;
		cmd.op = nhm64_pkg::OP_NONE;
		cmd.load_out = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					cmd.accept = 1'b1;
					if (stat.word_done) begin
						state_d = ST_K1;
					end else if (stat.last_in) begin
						state_d = ST_TAIL;
					end
				end
			end
			ST_K1: begin
				cmd.op = nhm64_pkg::OP_K1;
				state_d = ST_K2;
			end
			ST_K2: begin
				cmd.op = nhm64_pkg::OP_K2;
				state_d = ST_HALF;
			end
			ST_HALF: begin
				cmd.op = nhm64_pkg::OP_HALF;
				state_d = stat.last_held ? ST_TAIL : ST_IDLE;
			end
			ST_TAIL: begin
				cmd.op = nhm64_pkg::OP_TAIL;
				state_d = ST_F1;
			end
			ST_F1: begin
				cmd.op = nhm64_pkg::OP_F1;
				state_d = ST_F2;
			end
			ST_F2: begin
				cmd.op = nhm64_pkg::OP_F2;
				state_d = ST_F3;
			end
			ST_F3: begin
				cmd.op = nhm64_pkg::OP_F3;
				state_d = ST_F4;
			end
			ST_F4: begin
				cmd.op = nhm64_pkg::OP_F4;
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (stat.out_free) begin
					cmd.load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ rtl/nhm64_dpath.sv @@
module nhm64_dpath (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic [7:0]             data_byte,
	input  logic [7:0]             name_length,
	input  logic                   last_byte,
	input  logic                   seed_wr,
	input  logic [31:0]            seed_data,
	input  logic                   res_ready,
	output logic                   res_valid,
	output logic [62:0]            hash_value,
	output logic                   length_error,
	input  nhm64_pkg::nhm64_cmd_t  cmd,
	output nhm64_pkg::nhm64_stat_t stat
);

	logic [31:0] seed_q;
	logic        in_name_q;
	logic        out_valid_q;
	logic [31:0] h1_q;
	logic [31:0] h2_q;
	logic [31:0] k_q;
	logic [23:0] gather_q;
	logic [7:0]  seen_q;
	logic [7:0]  held_q;
	logic        parity_q;
	logic        over_q;
	logic        last_q;
	logic [62:0] hash_q;
	logic        err_q;

	logic        init;
	logic        skip;
	logic [7:0]  seen_b;
	logic [7:0]  held_b;
	logic [23:0] gather_b;
	logic        over_b;
	logic        parity_b;
	logic [1:0]  pos;
	logic [31:0] mul_a;
	logic [31:0] mul_p;
	logic        err_d;
	logic        out_free;

	// A first transaction of a name starts from fresh state.
	assign init = !in_name_q;
	assign skip = init && (name_length == 8'd0) && last_byte;
	assign seen_b = init ? 8'd0 : seen_q;
	assign held_b = init ? name_length : held_q;
	assign gather_b = init ? 24'd0 : gather_q;
	assign over_b = init ? 1'b0 : over_q;
	assign parity_b = init ? 1'b0 : parity_q;
	assign pos = seen_b[1:0];

	assign out_free = !out_valid_q || res_ready;

	assign stat.word_done = !skip && (pos == 2'd3);
	assign stat.last_in = last_byte;
	assign stat.last_held = last_q;
	assign stat.out_free = out_free;

	// Operand select for the one shared multiplier.
	always_comb begin
		case (cmd.op)
			nhm64_pkg::OP_K1: mul_a = k_q;
			nhm64_pkg::OP_K2: mul_a = k_q ^ (k_q >> nhm64_pkg::MIX_R);
			nhm64_pkg::OP_HALF: mul_a = parity_q ? h2_q : h1_q;
			nhm64_pkg::OP_TAIL: mul_a = h2_q ^ {8'd0, gather_q};
			nhm64_pkg::OP_F1: mul_a = h1_q ^ (h2_q >> nhm64_pkg::FIN_R1);
			nhm64_pkg::OP_F2: mul_a = h2_q ^ (h1_q >> nhm64_pkg::FIN_R2);
			nhm64_pkg::OP_F3: mul_a = h1_q ^ (h2_q >> nhm64_pkg::FIN_R3);
			nhm64_pkg::OP_F4: mul_a = h2_q ^ (h1_q >> nhm64_pkg::FIN_R4);
			default: mul_a = k_q;
		endcase
	end

	assign mul_p = nhm64_pkg::mul32(mul_a, nhm64_pkg::MIX_M);

	// Length check at the end of a name.
	assign err_d = over_q || (seen_q != held_q) ||
		(32'(held_q) > 32'(nhm64_pkg::MAX_NAME_BYTES));

	// Seed register, name tracking and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= nhm64_pkg::SEED_RST;
			in_name_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (seed_wr) begin
				seed_q <= seed_data;
			end
			if (cmd.accept) begin
				in_name_q <= 1'b1;
			end else if (cmd.load_out) begin
				in_name_q <= 1'b0;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Hash state, byte gathering and the output register.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			held_q <= held_b;
			last_q <= last_byte;
			if (init) begin
				h1_q <= seed_q ^ {24'd0, name_length};
				h2_q <= 32'd0;
			end
			if (skip) begin
				seen_q <= seen_b;
				gather_q <= gather_b;
				over_q <= over_b;
				parity_q <= parity_b;
			end else begin
				over_q <= over_b || (seen_b >= held_b);
				seen_q <= seen_b + 8'd1;
				parity_q <= parity_b;
				if (pos == 2'd3) begin
					k_q <= {data_byte, gather_b};
					gather_q <= 24'd0;
				end else begin
					gather_q <= gather_b | (24'(data_byte) << {pos, 3'b000});
				end
			end
		end
		case (cmd.op)
			nhm64_pkg::OP_K1, nhm64_pkg::OP_K2: begin
				k_q <= mul_p;
			end
			nhm64_pkg::OP_HALF: begin
				if (parity_q) begin
					h2_q <= mul_p ^ k_q;
				end else begin
					h1_q <= mul_p ^ k_q;
				end
				parity_q <= !parity_q;
			end
			nhm64_pkg::OP_TAIL: begin
				if (seen_q[1:0] != 2'd0) begin
					h2_q <= mul_p;
				end
			end
			nhm64_pkg::OP_F1, nhm64_pkg::OP_F3: begin
				h1_q <= mul_p;
			end
			nhm64_pkg::OP_F2, nhm64_pkg::OP_F4: begin
				h2_q <= mul_p;
			end
			default: begin
			end
		endcase
		if (cmd.load_out) begin
			hash_q <= {h1_q[30:0], h2_q};
			err_q <= err_d;
			gather_q <= 24'd0;
			parity_q <= 1'b0;
			over_q <= 1'b0;
		end
	end

	assign res_valid = out_valid_q;
	assign hash_value = hash_q;
	assign length_error = err_q;

endmodule

@@ rtl/name_hash_murmur64b_core.sv @@
// MurmurHash64B engine for names that arrive one byte per transaction on the
// item channel, each transaction carrying the declared name length, with
// last_byte marking the final byte. The first half starts as the seed register
// XOR the length; an empty name is one transaction with length zero and
// last_byte set. One result transaction is produced per name: a 63-bit hash
// and a flag that is set when the byte count differs from the declared length
// or the declared length exceeds the supported maximum. A byte that does not
// complete a 4-byte word needs no multiplier pass; a byte that completes a word
// is followed by the word scramble and the half update, which make three passes
// through the one shared 32x32 multiplier. The last byte of a name is followed
// by the tail mix, four finalization rounds and the load of the output register,
// which waits for the output register to be free, before the next name's first
// byte is taken. The output register lets a finished result wait while the next
// name streams in; a new result waits only while the previous one is still not
// taken. The seed register is written through the configuration channel, which
// is always ready, and is sampled at the first byte of each name.
module name_hash_murmur64b_core (
	input  logic           clk,
	input  logic           arst_n,
	nhm64_item_if.sink     item,
	nhm64_result_if.source result,
	nhm64_cfg_if.sink      cfg
);

	nhm64_pkg::nhm64_cmd_t  cmd;
	nhm64_pkg::nhm64_stat_t stat;

	assign cfg.ready = 1'b1;

	// Sequencer for byte intake, word mixing and finalization.
	nhm64_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item.ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	// Hash state, shared multiplier and output register.
	nhm64_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.data_byte    (item.data_byte),
		.name_length  (item.name_length),
		.last_byte    (item.last_byte),
		.seed_wr      (cfg.valid),
		.seed_data    (cfg.hash_seed),
		.res_ready    (result.ready),
		.res_valid    (result.valid),
		.hash_value   (result.hash_value),
		.length_error (result.length_error),
		.cmd          (cmd),
		.stat         (stat)
	);

endmodule
